FILE: src/cel_pkg.sv
// shared types, constants and helpers for the cross entropy loss unit
package cel_pkg;

  localparam int MaxClasses = 1024;
  localparam int MaxBatch   = 1024;
  localparam int CfgW       = 11;
  localparam int IdxW       = 10;
  localparam int ProbW      = 17;
  localparam int GradW      = 33;
  localparam int LossW      = 32;
  localparam int AccW       = 48;
  localparam int CntW       = 10;

  localparam logic [63:0] Ln2Q32  = 64'd2977044472;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  typedef enum logic [1:0] {
    REG_NUM_CLASSES = 2'd0,
    REG_BATCH_ROWS  = 2'd1,
    REG_TARGET_MODE = 2'd2
  } cfg_reg_t;

  // classified element from the front part to the back part
  typedef struct packed {
    logic [ProbW-1:0] prediction;
    logic [ProbW-1:0] target;
    logic [CfgW-1:0]  nb;
    logic             last;
    logic             error_code;
  } cel_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOG,
    BK_DIV_GRAD,
    BK_ACC,
    BK_DIV_LOSS,
    BK_OUT
  } bk_state_t;

  function automatic logic [CfgW-1:0] clamp_cfg(input logic [CfgW-1:0] v,
                                                input logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) r = CfgW'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

FILE: src/cel_if.sv
// valid/ready channel interfaces: input, output and configuration
interface cel_in_if;
  import cel_pkg::*;
  logic valid;
  logic ready;
  logic [ProbW-1:0] prediction;
  logic [ProbW-1:0] target_value;
  logic [IdxW-1:0]  target_index;
  modport source (output valid, prediction, target_value, target_index, input ready);
  modport sink (input valid, prediction, target_value, target_index, output ready);
endinterface

interface cel_out_if;
  import cel_pkg::*;
  logic valid;
  logic ready;
  logic signed [GradW-1:0] gradient;
  logic [LossW-1:0] loss;
  logic loss_valid;
  logic error_code;
  modport source (output valid, gradient, loss, loss_valid, error_code, input ready);
  modport sink (input valid, gradient, loss, loss_valid, error_code, output ready);
endinterface

interface cel_cfg_if;
  logic valid;
  logic ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/cel_front.sv
// front part: row/column tracking, target selection and error flag
module cel_front
  import cel_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  cel_in_if.sink          in_ch,
  cel_cfg_if.sink         cfg_ch,
  output logic            job_valid,
  input  logic            job_ready,
  output cel_job_t        job
);

  logic [CfgW-1:0] num_classes, batch_rows;
  logic            target_mode;
  logic [CntW-1:0] column_count, row_count, row_class_index;
  logic            index_error_seen;

  logic [CfgW-1:0] nc, nb;
  logic [CntW-1:0] cls_idx;
  logic            err_now, last_col, last, take;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = job_ready;
  assign job_valid    = in_ch.valid;
  assign take         = in_ch.valid && job_ready;

  assign nc = clamp_cfg(num_classes, CfgW'(MaxClasses));
  assign nb = clamp_cfg(batch_rows, CfgW'(MaxBatch));

  always_comb begin
    cls_idx = row_class_index;
    err_now = index_error_seen;
    if (target_mode && column_count == '0) begin
      cls_idx = in_ch.target_index;
      if ({1'b0, in_ch.target_index} >= nc) err_now = 1'b1;
    end
    last_col = ({1'b0, column_count} + CfgW'(1)) >= nc;
    last     = last_col && (({1'b0, row_count} + CfgW'(1)) >= nb);
    job.prediction = in_ch.prediction;
    if (target_mode) job.target = (column_count == cls_idx) ? ProbW'(65536) : '0;
    else job.target = in_ch.target_value;
    job.nb = nb;
    job.last = last;
    job.error_code = err_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= CfgW'(10);
      batch_rows <= CfgW'(1);
      target_mode <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_NUM_CLASSES: num_classes <= cfg_ch.data[CfgW-1:0];
        REG_BATCH_ROWS:  batch_rows <= cfg_ch.data[CfgW-1:0];
        REG_TARGET_MODE: target_mode <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      row_class_index <= '0;
      index_error_seen <= 1'b0;
    end else if (take) begin
      row_class_index <= cls_idx;
      if (last) begin
        column_count <= '0;
        row_count <= '0;
        index_error_seen <= 1'b0;
      end else begin
        index_error_seen <= err_now;
        if (last_col) begin
          column_count <= '0;
          row_count <= row_count + CntW'(1);
        end else begin
          column_count <= column_count + CntW'(1);
        end
      end
    end
  end

  a_idx_stable: assert property (@(posedge clk) disable iff (rst)
    (take && !last && !last_col) |=> (column_count == $past(column_count) + CntW'(1)))
    else $error("column count did not advance");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (take && last) |=> (column_count == '0 && row_count == '0 && !index_error_seen))
    else $error("batch end did not clear state");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (take && !last && err_now) |=> index_error_seen)
    else $error("error flag lost mid batch");

endmodule

FILE: src/cel_queue.sv
// two entry queue between front and back parts
module cel_queue
  import cel_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  cel_job_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output cel_job_t rd_data
);

  cel_job_t   mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count wrong on push");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 2'd1)
    else $error("queue count wrong on pop");

endmodule

FILE: src/cel_back.sv
// back part: log2 by squaring, a shared serial divider, loss accumulation, output register
module cel_back
  import cel_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  output logic     job_ready,
  input  cel_job_t job,
  cel_out_if.source out_ch
);

  bk_state_t state, state_next;
  cel_job_t  cur;
  logic [4:0]  step;
  logic [32:0] m;          // Q1.31 mantissa, up to 2.0
  logic [19:0] frac;
  logic [4:0]  expo;
  logic [31:0] nlog;       // Q16.16 log term
  logic        log_zero;
  logic [33:0] lin;
  logic [63:0] prod;
  logic [AccW-1:0] acc;
  // shared restoring divider
  logic [AccW-1:0] dq;     // dividend shifting into quotient
  logic [28:0] drem;
  logic [27:0] dden;
  logic [5:0]  dcnt;
  logic [32:0] grad_q;
  logic        out_valid;
  logic        out_load;
  logic signed [GradW-1:0] out_grad;
  logic [LossW-1:0] out_loss;
  logic out_lv, out_err;

  logic [17:0] v;
  logic [65:0] sq;
  logic [4:0]  e_n;
  logic [28:0] rtry;
  logic [AccW:0] acc_sum;
  logic [AccW-1:0] acc_new;

  assign job_ready = (state == BK_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.gradient = out_grad;
  assign out_ch.loss = out_loss;
  assign out_ch.loss_valid = out_lv;
  assign out_ch.error_code = out_err;

  assign out_load = (state == BK_OUT) && (!out_valid || out_ch.ready);

  assign v = {1'b0, job.prediction} + 18'd1;
  always_comb begin
    e_n = '0;
    for (int i = 1; i < 16; i++) if (v[i]) e_n = 5'(i);
  end
  assign sq = {33'd0, m} * {33'd0, m};
  assign rtry = {drem[27:0], dq[AccW-1]} - {1'b0, dden};
  // loss term t * -ln(p) in Q.16, added with saturation
  assign prod = 64'(cur.target) * 64'(nlog);
  assign acc_sum = {1'b0, acc} + {1'b0, prod[63:16]};
  assign acc_new = acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:     if (job_valid) state_next = BK_LOG;
      BK_LOG:      if (log_zero || step == 5'd20) state_next = BK_DIV_GRAD;
      BK_DIV_GRAD: if (dcnt == '0) state_next = BK_ACC;
      BK_ACC:      state_next = cur.last ? BK_DIV_LOSS : BK_OUT;
      BK_DIV_LOSS: if (dcnt == '0) state_next = BK_OUT;
      BK_OUT:      if (!out_valid || out_ch.ready) state_next = BK_IDLE;
      default:     state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
      acc <= '0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        BK_IDLE: if (job_valid) begin
          cur <= job;
          step <= '0;
          frac <= '0;
          expo <= e_n;
          log_zero <= v[17] | v[16];
          m <= 33'({15'd0, v} << (5'd31 - e_n));
        end
        BK_LOG: begin
          if (log_zero || step == 5'd20) begin
            // set up gradient division: (t<<16) / (max(p,1)*nb)
            dq <= AccW'({cur.target, 16'd0}) << 15;
            drem <= '0;
            dden <= 28'((cur.prediction == '0 ? 17'd1 : cur.prediction) * cur.nb);
            dcnt <= 6'd33;
          end else begin
            step <= step + 5'd1;
            if (sq[63]) begin
              m <= sq[64:32];
              frac <= {frac[18:0], 1'b1};
            end else begin
              m <= sq[63:31];
              frac <= {frac[18:0], 1'b0};
            end
          end
          lin <= 34'((({14'd0, 5'd16 - expo} << 20) - {14'd0, frac}));
        end
        BK_DIV_GRAD, BK_DIV_LOSS: begin
          if (dcnt != '0) begin
            dcnt <= dcnt - 6'd1;
            if (!rtry[28]) begin
              drem <= rtry;
              dq <= {dq[AccW-2:0], 1'b1};
            end else begin
              drem <= {drem[27:0], dq[AccW-1]};
              dq <= {dq[AccW-2:0], 1'b0};
            end
          end
          if (state == BK_DIV_GRAD) begin
            nlog <= log_zero ? '0 : 32'(({30'd0, lin} * Ln2Q32 + (64'd1 << 35)) >> 36);
          end
        end
        BK_ACC: begin
          grad_q <= dq[32:0];
          if (cur.last) begin
            // batch end: divide the final sum by the row count, restart the sum
            acc <= '0;
            dq <= acc_new;
            drem <= '0;
            dden <= 28'(cur.nb);
            dcnt <= 6'd48;
          end else begin
            acc <= acc_new;
          end
        end
        BK_OUT: if (out_load) begin
          out_err <= cur.error_code;
          out_lv <= cur.last;
          out_grad <= GradW'(33'd0 - ((grad_q > 33'h1_0000_0000) ? 33'h1_0000_0000 : grad_q));
          out_loss <= cur.last ? ((dq[AccW-1:32] != '0) ? '1 : dq[31:0]) : '0;
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_grad) &&
      $stable(out_loss) && $stable(out_lv) && $stable(out_err)))
    else $error("result changed while waiting");
  a_loss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_lv) |-> (out_loss == '0))
    else $error("loss given outside batch end");
  a_grad_len: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV_GRAD) |-> (dcnt <= 6'd33))
    else $error("gradient division too long");

endmodule

FILE: src/cross_entropy_loss_and_gradient_unit.sv
// top level of the cross entropy loss and gradient unit
// One result per accepted element, in order. The front part's data path is
// combinational: it tracks row and column, picks the dense or one-hot target,
// latches the row's class index at column 0 and raises the sticky index error.
// An element is written into a two-entry queue at the edge that accepts the
// request. The back part takes one queued element at a time: it takes it in,
// runs the log2 unit (20 squaring steps, then a step to set up the divider),
// runs the serial divider for the gradient (33 quotient bits, then a finishing
// step), adds the loss term and loads the output register. When p+1 is at or
// above one the log term is zero and the squaring steps are skipped. The last
// element of a batch also runs the 48 bit loss division by the row count before
// the output register is loaded. A result waiting in the output register holds
// the back part, and once the queue is full the input ready drops.
// Configuration writes are meant for times when no request is in flight.
module cross_entropy_loss_and_gradient_unit
  import cel_pkg::*;
(
  input logic clk,
  input logic rst,
  cel_in_if.sink    in_ch,
  cel_cfg_if.sink   cfg_ch,
  cel_out_if.source out_ch
);

  // classified elements from the front part into the queue
  logic     fe_valid, fe_ready;
  cel_job_t fe_job;
  // queue head towards the back part
  logic     bk_valid, bk_ready;
  cel_job_t bk_job;

  cel_front i_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .job_valid (fe_valid),
    .job_ready (fe_ready),
    .job       (fe_job)
  );

  // decouples the front part from the long back part
  cel_queue i_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_job),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_data  (bk_job)
  );

  cel_back i_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/sv/cel_loss_checker.sv
// watches the unit's channels, predicts each result and compares it
module cel_loss_checker
  import cel_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cel_in_if    in_ch,
  cel_cfg_if   cfg_ch,
  cel_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   losses_seen,
  output int   errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [GradW-1:0] gradient;
    logic [LossW-1:0] loss;
    logic             loss_valid;
    logic             error_code;
  } cel_result_t;

  cel_result_t result_q[$];

  logic [CfgW-1:0] classes_reg, rows_reg;
  logic            index_mode;
  logic [CntW-1:0] col_cnt, row_cnt, class_idx;
  logic [63:0]     loss_acc;
  logic            idx_err;

  // -ln((p+1)/65536) in Q16.16, zero at or above one
  function automatic logic [63:0] neg_ln_q16(input logic [ProbW-1:0] p);
    logic [63:0] v, m, frac, n;
    int e;
    v = 64'(p) + 64'd1;
    frac = '0;
    e = 0;
    if (v >= 64'd65536) return '0;
    while (e < 15 && (v >> (e + 1)) != 0) e++;
    m = v << (31 - e);
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    n = (64'(16 - e) << 20) - frac;
    return (n * Ln2Q32 + (64'd1 << 35)) >> 36;
  endfunction

  function automatic logic [63:0] eff(input logic [CfgW-1:0] v, input int hi);
    if (v == 0) return 64'd1;
    if (v > hi) return 64'(hi);
    return 64'(v);
  endfunction

  always @(posedge clk) begin
    logic [63:0] nc, nb, t, pe, q, l;
    cel_result_t exp_r, got;
    logic last_col, last;
    if (rst) begin
      classes_reg  <= CfgW'(10);
      rows_reg     <= CfgW'(1);
      index_mode   <= 1'b0;
      col_cnt      <= '0;
      row_cnt      <= '0;
      class_idx    <= '0;
      loss_acc     <= '0;
      idx_err      <= 1'b0;
      fail_count   <= 0;
      results_seen <= 0;
      losses_seen  <= 0;
      errors_seen  <= 0;
      result_q.delete();
    end else begin
      // register writes must happen only while idle; this checker does not enforce it
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_NUM_CLASSES: classes_reg <= cfg_ch.data[CfgW-1:0];
          REG_BATCH_ROWS:  rows_reg <= cfg_ch.data[CfgW-1:0];
          REG_TARGET_MODE: index_mode <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        logic [CntW-1:0] ci;
        logic            ie;
        nc = eff(classes_reg, MaxClasses);
        nb = eff(rows_reg, MaxBatch);
        ci = class_idx;
        ie = idx_err;
        if (index_mode && col_cnt == 0) begin
          ci = in_ch.target_index;
          if (64'(in_ch.target_index) >= nc) ie = 1'b1;
        end
        if (index_mode) t = (col_cnt == ci) ? 64'd65536 : 64'd0;
        else t = 64'(in_ch.target_value);
        pe = (in_ch.prediction == 0) ? 64'd1 : 64'(in_ch.prediction);
        q = (t << 16) / (pe * nb);
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
        exp_r.gradient = GradW'(64'd0 - q);
        l = loss_acc + ((t * neg_ln_q16(in_ch.prediction)) >> 16);
        if (l > 64'(AccMax)) l = 64'(AccMax);
        last_col = (64'(col_cnt) + 1 >= nc);
        last = last_col && (64'(row_cnt) + 1 >= nb);
        exp_r.error_code = ie;
        exp_r.loss_valid = last;
        if (last) begin
          l = l / nb;
          exp_r.loss = (l > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : l[31:0];
          col_cnt  <= '0;
          row_cnt  <= '0;
          loss_acc <= '0;
          idx_err  <= 1'b0;
        end else begin
          exp_r.loss = '0;
          loss_acc <= l;
          idx_err  <= ie;
          if (last_col) begin
            col_cnt <= '0;
            row_cnt <= row_cnt + 1'b1;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
        end
        class_idx <= ci;
        result_q.push_back(exp_r);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.gradient   = out_ch.gradient;
        got.loss       = out_ch.loss;
        got.loss_valid = out_ch.loss_valid;
        got.error_code = out_ch.error_code;
        results_seen <= results_seen + 1;
        if (got.loss_valid) losses_seen <= losses_seen + 1;
        if (got.error_code) errors_seen <= errors_seen + 1;
        if (result_q.size() == 0) begin
          $display("%0t: result with none expected: grad %h loss %h lv %b err %b",
                   $time, got.gradient, got.loss, got.loss_valid, got.error_code);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got.gradient !== exp_r.gradient || got.loss !== exp_r.loss ||
              got.loss_valid !== exp_r.loss_valid ||
              got.error_code !== exp_r.error_code) begin
            $display("%0t: expected grad %h loss %h lv %b err %b, got grad %h loss %h lv %b err %b",
                     $time, exp_r.gradient, exp_r.loss, exp_r.loss_valid, exp_r.error_code,
                     got.gradient, got.loss, got.loss_valid, got.error_code);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = result_q.size();

endmodule

FILE: tb/sv/tb_top.sv
// top of the cross entropy loss unit testbench: stimulus, backpressure, verdict
module tb_top
  import cel_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;

  cel_in_if  in_ch ();
  cel_cfg_if cfg_ch ();
  cel_out_if out_ch ();

  int fail_count, pending, results_seen, losses_seen, errors_seen;
  int gap_max;       // per phase sender idle bound, 0 means back to back
  int stall_max;     // per phase receiver idle bound
  bit hold_request;  // asks the receiver for one long hold-off
  int cur_classes;   // effective classes, only for shaping indexes
  int idle_cycles;

  cross_entropy_loss_and_gradient_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  cel_loss_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .losses_seen  (losses_seen),
    .errors_seen  (errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: too long without any request moving on any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
        $display("timeout at %0t", $time);
        $display("cross_entropy_loss_and_gradient_unit: mismatch");
        $finish;
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = $urandom_range(0, stall_max);
      if (hold_request) begin
        // long stretch so the block fills up and stops taking requests
        n = 400;
        hold_request = 1'b0;
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
      while (!out_ch.valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // one element request, with a random gap ahead of it
  task automatic send_element(input logic [ProbW-1:0] p, input logic [ProbW-1:0] tv,
                              input logic [IdxW-1:0] ti);
    int n;
    n = $urandom_range(0, gap_max);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.prediction   <= p;
    in_ch.target_value <= tv;
    in_ch.target_index <= ti;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // wait for the block to drain, then write one register
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(input int nc, input int nb, input int mode);
    write_reg(REG_NUM_CLASSES, 32'(nc));
    write_reg(REG_BATCH_ROWS, 32'(nb));
    write_reg(REG_TARGET_MODE, 32'(mode));
    cur_classes = (nc == 0) ? 1 : (nc > MaxClasses ? MaxClasses : nc);
  endtask

  // probabilities weighted toward the corners, full 17 bit range included
  function automatic logic [ProbW-1:0] rand_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ProbW'(65536);
      2: return ProbW'($urandom_range(65530, 65536));
      3: return ProbW'($urandom_range(65537, 131071));
      4: return ProbW'($urandom_range(1, 16));
      default: return ProbW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [IdxW-1:0] rand_index();
    if ($urandom_range(0, 7) == 0) return IdxW'($urandom);
    return IdxW'($urandom_range(0, cur_classes - 1));
  endfunction

  task automatic random_elements(input int count);
    repeat (count) send_element(rand_prob(), rand_prob(), rand_index());
  endtask

  initial begin
    int nc, nb;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.prediction = '0;
    in_ch.target_value = '0;
    in_ch.target_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    gap_max = 10;
    stall_max = 10;
    hold_request = 1'b0;
    cur_classes = 10;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: dense, ten classes, one row
    send_element('0, ProbW'(65536), '0);              // zero prediction, saturated gradient
    send_element('0, '1, '1);                         // gradient far past saturation
    send_element(ProbW'(65536), ProbW'(65536), '0);   // probability of one
    send_element(ProbW'(65535), ProbW'(65536), '0);   // just under one
    send_element('1, '1, '0);                         // above one, log clamps to zero
    send_element(ProbW'(1), '0, '0);
    send_element(ProbW'(1), ProbW'(1), '0);
    send_element(ProbW'(32768), ProbW'(32768), '0);
    send_element(ProbW'(12345), ProbW'(54321), '0);
    send_element(ProbW'(100), ProbW'(65536), '0);     // closes the batch

    // index mode, four classes by two rows
    set_config(4, 2, 1);
    send_element(ProbW'(65536), '0, IdxW'(0));
    repeat (3) send_element(ProbW'(1000), '1, '0);
    send_element(ProbW'(20000), '0, IdxW'(3));
    repeat (3) send_element(ProbW'(20000), '0, '0);
    send_element('0, '0, IdxW'(4));                   // out of range, no hot column
    repeat (3) send_element(ProbW'(5), '0, '0);
    send_element(ProbW'(7), '0, '1);                  // largest index
    send_element(ProbW'(7), '0, '0);
    // mode change mid row keeps the latched index
    set_config(4, 2, 0);
    send_element(ProbW'(9), ProbW'(65536), '0);
    set_config(4, 2, 1);
    send_element(ProbW'(9), '0, IdxW'(2));
    send_element(ProbW'(9), '0, IdxW'(2));

    // random phases, small sizes, some mid-batch reconfiguration
    for (int ph = 0; ph < 14; ph++) begin
      nc = $urandom_range(1, 12);
      nb = $urandom_range(1, 4);
      if (ph == 3) nc = 0;
      if (ph == 5) nb = 0;
      gap_max = (ph % 4 == 1) ? 0 : 10;
      stall_max = (ph % 4 == 2) ? 0 : 10;
      set_config(nc, nb, $urandom_range(0, 1));
      if (ph == 6) begin
        gap_max = 0;
        hold_request = 1'b1;
      end
      random_elements($urandom_range(18, 36));
    end

    // largest sizes, clamped from above: part of a wide row, part of a tall batch, then zero sizes clamped to one
    gap_max = 2;
    stall_max = 2;
    set_config(2047, 1, 1);
    random_elements(8);
    set_config(1, 2047, 0);
    random_elements(8);
    set_config(1024, 1024, 0);
    random_elements(6);
    set_config(0, 0, 1);
    random_elements(10);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d results, %0d batch losses, %0d flagged index errors",
             results_seen, losses_seen, errors_seen);
    $display("dense and index targets, clamped sizes, saturation and long stalls");
    if (fail_count == 0) begin
      $display("cross_entropy_loss_and_gradient_unit: match");
    end else begin
      $display("cross_entropy_loss_and_gradient_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
src/cel_pkg.sv
src/cel_if.sv
src/cel_front.sv
src/cel_queue.sv
src/cel_back.sv
src/cross_entropy_loss_and_gradient_unit.sv
tb/sv/cel_loss_checker.sv
tb/sv/tb_top.sv
